@@ rtl/scta_pkg.sv @@
package scta_pkg;

  // ring and queue sizing
  localparam int RING_DEPTH_DEF = 256;
  localparam int OPQ_DEPTH      = 2;
  localparam int OUT_DEPTH      = 4;
  localparam int OUT_AW         = $clog2(OUT_DEPTH);
  localparam int OUT_CW         = $clog2(OUT_DEPTH + 1);

  // configuration register indexes
  localparam logic [1:0] CFG_UP_ARROW    = 2'd0;
  localparam logic [1:0] CFG_DOWN_ARROW  = 2'd1;
  localparam logic [1:0] CFG_LEFT_ARROW  = 2'd2;
  localparam logic [1:0] CFG_RIGHT_ARROW = 2'd3;

  localparam logic [7:0] UP_ARROW_RST    = 8'h80;
  localparam logic [7:0] DOWN_ARROW_RST  = 8'h81;
  localparam logic [7:0] LEFT_ARROW_RST  = 8'h82;
  localparam logic [7:0] RIGHT_ARROW_RST = 8'h83;

  // input function codes
  localparam logic FUNC_SCAN = 1'b0;
  localparam logic FUNC_READ = 1'b1;

  // set 1 scancodes
  localparam logic [7:0] SC_EXT_PREFIX   = 8'hE0;
  localparam logic [7:0] SC_UP           = 8'h48;
  localparam logic [7:0] SC_DOWN         = 8'h50;
  localparam logic [7:0] SC_LEFT         = 8'h4B;
  localparam logic [7:0] SC_RIGHT        = 8'h4D;
  localparam logic [7:0] SC_LSHIFT_MAKE  = 8'h2A;
  localparam logic [7:0] SC_RSHIFT_MAKE  = 8'h36;
  localparam logic [7:0] SC_LSHIFT_BREAK = 8'hAA;
  localparam logic [7:0] SC_RSHIFT_BREAK = 8'hB6;

  localparam int TABLE_LEN = 58;

  localparam logic [7:0] PLAIN_MAP [TABLE_LEN] = '{
    8'h00, 8'h1B, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30,
    8'h2D, 8'h3D, 8'h08, 8'h09, 8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73, 8'h64, 8'h66, 8'h67, 8'h68,
    8'h6A, 8'h6B, 8'h6C, 8'h3B, 8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  localparam logic [7:0] SHIFTED_MAP [TABLE_LEN] = '{
    8'h00, 8'h1B, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h28, 8'h29,
    8'h5F, 8'h2B, 8'h08, 8'h09, 8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53, 8'h44, 8'h46, 8'h47, 8'h48,
    8'h4A, 8'h4B, 8'h4C, 8'h3A, 8'h22, 8'h60, 8'h00, 8'h5C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A, 8'h00, 8'h20
  };

  // operation passed from the decoder to the ring side
  typedef struct packed {
    logic       is_read;
    logic [7:0] ch;
  } scta_op_t;

endpackage

@@ rtl/scancode_to_ascii_key_fifo_unit.sv @@
// a read goes through the op queue and ring read register before out_empty falls
// throughput: one item per cycle, reads and scancodes alike; only a full result
// queue (consumer not popping) holds back reads, and that backs up to in_full
// the ring is one write port and one registered read port, one access per cycle
// reset (rst_n low, synchronous): flags, pointers and queues clear, arrow codes
// return to 0x80..0x83; ring contents are not cleared and need no clearing pass
module scancode_to_ascii_key_fifo_unit #(
  parameter int RING_DEPTH = scta_pkg::RING_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // input channel, queue style
  input  logic       in_push,
  output logic       in_full,
  input  logic       in_func,
  input  logic [7:0] in_scan_byte,
  // result channel, queue style
  output logic       out_empty,
  input  logic       out_pop,
  output logic [7:0] out_char_out,
  output logic       out_was_empty,
  // configuration writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);
  import scta_pkg::*;

  // front to queue
  logic     fr_push;
  scta_op_t fr_op;
  logic     opq_full;

  // queue to back
  logic     opq_valid;
  scta_op_t opq_head;
  logic     bk_pop;

  // front: takes each transaction, tracks shift and extended prefix, maps
  // scancodes to characters and emits a write or read operation
  scta_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_full      (in_full),
    .in_func      (in_func),
    .in_scan_byte (in_scan_byte),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .opq_full     (opq_full),
    .op_push      (fr_push),
    .op           (fr_op)
  );

  // short operation queue decoupling decode from the ring
  scta_opq u_opq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (fr_push),
    .push_op (fr_op),
    .full    (opq_full),
    .valid   (opq_valid),
    .head_op (opq_head),
    .pop     (bk_pop)
  );

  // back: character ring plus result queue; a full ring wraps and looks empty
  scta_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .op_valid      (opq_valid),
    .op            (opq_head),
    .op_pop        (bk_pop),
    .out_empty     (out_empty),
    .out_pop       (out_pop),
    .out_char_out  (out_char_out),
    .out_was_empty (out_was_empty)
  );

endmodule

@@ rtl/scta_front.sv @@
module scta_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic              in_func,
  input  logic [7:0]        in_scan_byte,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic              opq_full,
  output logic              op_push,
  output scta_pkg::scta_op_t op
);
  import scta_pkg::*;

  logic [7:0] up_code_r, down_code_r, left_code_r, right_code_r;
  logic       shift_r, shift_nxt;
  logic       ext_r, ext_nxt;
  logic       accept;
  logic [7:0] map_ch;

  assign in_full = opq_full;
  assign accept  = in_push && !opq_full;

  always_comb begin
    map_ch = 8'h00;
    if (in_scan_byte < 8'(TABLE_LEN)) begin
      map_ch = shift_r ? SHIFTED_MAP[in_scan_byte[5:0]] : PLAIN_MAP[in_scan_byte[5:0]];
    end
  end

  // classify one item
  always_comb begin
    shift_nxt  = shift_r;
    ext_nxt    = ext_r;
    op_push    = 1'b0;
    op.is_read = 1'b0;
    op.ch      = 8'h00;
    if (accept) begin
      if (in_func == FUNC_READ) begin
        op_push    = 1'b1;
        op.is_read = 1'b1;
      end else if (in_scan_byte == SC_EXT_PREFIX) begin
        ext_nxt = 1'b1;
      end else if (ext_r) begin
        ext_nxt = 1'b0;
        unique case (in_scan_byte)
          SC_UP: begin
            op_push = 1'b1;
            op.ch   = up_code_r;
          end
          SC_DOWN: begin
            op_push = 1'b1;
            op.ch   = down_code_r;
          end
          SC_LEFT: begin
            op_push = 1'b1;
            op.ch   = left_code_r;
          end
          SC_RIGHT: begin
            op_push = 1'b1;
            op.ch   = right_code_r;
          end
          default: begin
            op_push = 1'b0;
          end
        endcase
      end else if (in_scan_byte == SC_LSHIFT_MAKE || in_scan_byte == SC_RSHIFT_MAKE) begin
        shift_nxt = 1'b1;
      end else if (in_scan_byte == SC_LSHIFT_BREAK || in_scan_byte == SC_RSHIFT_BREAK) begin
        shift_nxt = 1'b0;
      end else if (!in_scan_byte[7]) begin
        op_push = (map_ch != 8'h00);
        op.ch   = map_ch;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r      <= 1'b0;
      ext_r        <= 1'b0;
      up_code_r    <= UP_ARROW_RST;
      down_code_r  <= DOWN_ARROW_RST;
      left_code_r  <= LEFT_ARROW_RST;
      right_code_r <= RIGHT_ARROW_RST;
    end else begin
      shift_r <= shift_nxt;
      ext_r   <= ext_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_UP_ARROW:    up_code_r    <= cfg_data;
          CFG_DOWN_ARROW:  down_code_r  <= cfg_data;
          CFG_LEFT_ARROW:  left_code_r  <= cfg_data;
          CFG_RIGHT_ARROW: right_code_r <= cfg_data;
          default:         up_code_r    <= up_code_r;
        endcase
      end
    end
  end

endmodule

@@ rtl/scta_opq.sv @@
module scta_opq (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  scta_pkg::scta_op_t push_op,
  output logic               full,
  output logic               valid,
  output scta_pkg::scta_op_t head_op,
  input  logic               pop
);
  import scta_pkg::*;

  localparam int AW = $clog2(OPQ_DEPTH);
  localparam int CW = $clog2(OPQ_DEPTH + 1);

  scta_op_t       slot_r [OPQ_DEPTH];
  logic [AW-1:0]  wptr_r, rptr_r;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic           do_push, do_pop;

  assign full    = (cnt_r == CW'(OPQ_DEPTH));
  assign valid   = (cnt_r != '0);
  assign head_op = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = pop && valid;

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wptr_r <= (wptr_r == AW'(OPQ_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (do_pop) begin
        rptr_r <= (rptr_r == AW'(OPQ_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wptr_r] <= push_op;
    end
  end

endmodule

@@ rtl/scta_back.sv @@
module scta_back #(
  parameter int RING_DEPTH = scta_pkg::RING_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  scta_pkg::scta_op_t op,
  output logic               op_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output logic [7:0]         out_char_out,
  output logic               out_was_empty
);
  import scta_pkg::*;

  localparam int AW = $clog2(RING_DEPTH);

  logic [7:0]        ring_mem [RING_DEPTH];
  logic [AW-1:0]     wptr_r, rptr_r;
  logic [7:0]        rd_data_r;
  logic              s2_valid_r, s2_empty_r;
  logic              ring_empty, out_room, issue, issue_read, issue_write, mem_rd;

  logic [8:0]        oq_r [OUT_DEPTH];
  logic [OUT_AW-1:0] oq_wptr_r, oq_rptr_r;
  logic [OUT_CW-1:0] oq_cnt_r, oq_cnt_nxt;
  logic [OUT_CW:0]   oq_used;
  logic              oq_push, oq_pop;
  logic [8:0]        oq_head;

  // slots already promised to the output queue, including the one in flight
  assign oq_used     = {1'b0, oq_cnt_r} + (OUT_CW + 1)'(s2_valid_r);
  assign out_room    = (oq_used < (OUT_CW + 1)'(OUT_DEPTH));
  assign ring_empty  = (rptr_r == wptr_r);
  assign issue       = op_valid && (!op.is_read || out_room);
  assign issue_read  = issue && op.is_read;
  assign issue_write = issue && !op.is_read;
  assign mem_rd      = issue_read && !ring_empty;
  assign op_pop      = issue;

  always_ff @(posedge clk) begin
    if (issue_write) begin
      ring_mem[wptr_r] <= op.ch;
    end
    if (mem_rd) begin
      rd_data_r <= ring_mem[rptr_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r     <= '0;
      rptr_r     <= '0;
      s2_valid_r <= 1'b0;
      s2_empty_r <= 1'b0;
    end else begin
      s2_valid_r <= issue_read;
      s2_empty_r <= issue_read && ring_empty;
      if (issue_write) begin
        wptr_r <= (wptr_r == AW'(RING_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
      end
      if (mem_rd) begin
        rptr_r <= (rptr_r == AW'(RING_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
      end
    end
  end

  // result queue
  assign oq_push       = s2_valid_r;
  assign oq_pop        = out_pop && !out_empty;
  assign out_empty     = (oq_cnt_r == '0);
  assign oq_head       = oq_r[oq_rptr_r];
  assign out_char_out  = oq_head[7:0];
  assign out_was_empty = oq_head[8];

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !oq_pop) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (oq_pop && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wptr_r <= '0;
      oq_rptr_r <= '0;
      oq_cnt_r  <= '0;
    end else begin
      oq_cnt_r <= oq_cnt_nxt;
      if (oq_push) begin
        oq_wptr_r <= oq_wptr_r + 1'b1;
      end
      if (oq_pop) begin
        oq_rptr_r <= oq_rptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wptr_r] <= s2_empty_r ? 9'h100 : {1'b0, rd_data_r};
    end
  end

`ifndef SYNTHESIS
  a_oq_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    oq_used <= (OUT_CW + 1)'(OUT_DEPTH))
    else $error("result queue overcommitted");

  a_read_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    issue_read |=> s2_valid_r)
    else $error("issued read produced no result");

  a_empty_read_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (issue_read && ring_empty) |=> (s2_empty_r && $stable(rptr_r)))
    else $error("read of empty ring not flagged");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (op_valid && !op.is_read) |=> !s2_valid_r)
    else $error("character write produced a result");
`endif

endmodule
